>>> sv/threshold_map_statistics_assert.svh
// Assertion macros used by the checker file of the threshold map statistics block.
`ifndef THRESHOLD_MAP_STATISTICS_ASSERT_SVH
`define THRESHOLD_MAP_STATISTICS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("threshold map statistics assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("threshold map statistics assertion failed");

`endif

>>> sv/tms_pkg.sv
// Package with types and constants of the threshold map statistics block.
package tms_pkg;

   localparam logic [7:0]  ThrInvalid = 8'd255;
   localparam logic [12:0] CountMax   = 13'd8191;

   localparam int CntW      = 5;
   localparam int MeanQuoW  = 16;
   localparam int RmsQuoW   = 30;
   localparam int SqrtSteps = 15;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_MULT,
      ST_DIFF,
      ST_DIV_MEAN,
      ST_RMS_LOAD,
      ST_DIV_RMS,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_OUT
   } tms_state_type;

   typedef struct packed {
      logic accum;
      logic mult;
      logic diff;
      logic div_load_mean;
      logic div_step;
      logic mean_save;
      logic div_load_rms;
      logic sqrt_load;
      logic sqrt_step;
      logic out_load;
   } tms_cmd_type;

   typedef struct packed {
      logic out_free;
   } tms_status_type;

endpackage

>>> sv/tms_ctrl.sv
// Controller state machine of the threshold map statistics block.
module tms_ctrl import tms_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last_pixel,
   output logic           req_stall,
   input  tms_status_type status,
   output tms_cmd_type    cmd
);

   tms_state_type   state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_ACCUM: begin
            req_stall = 1'b0;
            cmd.accum = req_valid;
            if (req_valid && req_last_pixel) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff          = 1'b1;
            cmd.div_load_mean = 1'b1;
            cnt_in            = CntW'(MeanQuoW - 1);
            state_in          = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_RMS_LOAD;
            end
         end
         ST_RMS_LOAD: begin
            cmd.mean_save    = 1'b1;
            cmd.div_load_rms = 1'b1;
            cnt_in           = CntW'(RmsQuoW - 1);
            state_in         = ST_DIV_RMS;
         end
         ST_DIV_RMS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SQRT_LOAD;
            end
         end
         ST_SQRT_LOAD: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = CntW'(SqrtSteps - 1);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

>>> sv/tms_dpath.sv
// Datapath of the threshold map statistics block: accumulators, divider, root and result register.
module tms_dpath import tms_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tms_cmd_type    cmd,
   output tms_status_type status,
   input  logic [7:0]     req_threshold,
   input  logic [5:0]     req_pixel_col,
   input  logic [6:0]     req_pixel_row,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [12:0]    rsp_valid_count,
   output logic           rsp_min_found,
   output logic [7:0]     rsp_min_value,
   output logic [5:0]     rsp_min_col,
   output logic [6:0]     rsp_min_row,
   output logic           rsp_max_found,
   output logic [7:0]     rsp_max_value,
   output logic [5:0]     rsp_max_col,
   output logic [6:0]     rsp_max_row,
   output logic [15:0]    rsp_mean_q8,
   output logic [15:0]    rsp_rms_q8
);

   logic [20:0] sum_ff;
   logic [28:0] sumsq_ff;
   logic [12:0] count_ff;
   logic [7:0]  min_ff, max_ff;
   logic [5:0]  min_col_ff, max_col_ff;
   logic [6:0]  min_row_ff, max_row_ff;

   logic [41:0] qn_ff, ss_ff, num_ff;

   logic [26:0]        rem_ff;
   logic [RmsQuoW-1:0] low_ff, quo_ff;
   logic [25:0]        dsr_ff;
   logic [27:0]        trial;
   logic [15:0]        mean_ff;

   logic [29:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [30:0] sq_sum;

   logic        rsp_valid_ff;
   logic [12:0] out_count_ff;
   logic        out_min_found_ff, out_max_found_ff;
   logic [7:0]  out_min_ff, out_max_ff;
   logic [5:0]  out_min_col_ff, out_max_col_ff;
   logic [6:0]  out_min_row_ff, out_max_row_ff;
   logic [15:0] out_mean_ff, out_rms_ff;

   logic        thr_ok;
   logic [15:0] thr_sq;

   assign thr_ok = (req_threshold != ThrInvalid) && (count_ff != CountMax);
   assign thr_sq = req_threshold * req_threshold;

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         sum_ff     <= '0;
         sumsq_ff   <= '0;
         count_ff   <= '0;
         min_ff     <= ThrInvalid;
         min_col_ff <= '0;
         min_row_ff <= '0;
         max_ff     <= '0;
         max_col_ff <= '0;
         max_row_ff <= '0;
      end else if (cmd.accum) begin
         if (thr_ok) begin
            sum_ff   <= sum_ff + 21'(req_threshold);
            sumsq_ff <= sumsq_ff + 29'(thr_sq);
            count_ff <= count_ff + 1'b1;
         end
         if ((req_threshold != 8'd0) && (req_threshold < min_ff)) begin
            min_ff     <= req_threshold;
            min_col_ff <= req_pixel_col;
            min_row_ff <= req_pixel_row;
         end
         if ((req_threshold > max_ff) && (req_threshold != ThrInvalid)) begin
            max_ff     <= req_threshold;
            max_col_ff <= req_pixel_col;
            max_row_ff <= req_pixel_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         qn_ff <= 42'(sumsq_ff * count_ff);
         ss_ff <= 42'(sum_ff * sum_ff);
      end
      if (cmd.diff) begin
         num_ff <= qn_ff - ss_ff;
      end
   end

   assign trial = {rem_ff, low_ff[RmsQuoW-1]} - {2'b00, dsr_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load_mean) begin
         rem_ff <= {14'd0, sum_ff[20:8]};
         low_ff <= {sum_ff[7:0], 22'd0};
         quo_ff <= '0;
         dsr_ff <= 26'(count_ff);
      end else if (cmd.div_load_rms) begin
         rem_ff <= num_ff[40:14];
         low_ff <= {num_ff[13:0], 16'd0};
         quo_ff <= '0;
         dsr_ff <= 26'(count_ff * count_ff);
      end else if (cmd.div_step) begin
         low_ff <= {low_ff[RmsQuoW-2:0], 1'b0};
         if (!trial[27]) begin
            rem_ff <= trial[26:0];
            quo_ff <= {quo_ff[RmsQuoW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[25:0], low_ff[RmsQuoW-1]};
            quo_ff <= {quo_ff[RmsQuoW-2:0], 1'b0};
         end
      end
      if (cmd.mean_save) begin
         mean_ff <= quo_ff[15:0];
      end
   end

   assign sq_sum = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         sq_v_ff   <= quo_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= 30'd1 << 28;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, sq_v_ff} >= sq_sum) begin
            sq_v_ff   <= sq_v_ff - sq_sum[29:0];
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_count_ff     <= count_ff;
         out_min_found_ff <= (min_ff != ThrInvalid);
         out_min_ff       <= min_ff;
         out_min_col_ff   <= min_col_ff;
         out_min_row_ff   <= min_row_ff;
         out_max_found_ff <= (max_ff != 8'd0);
         out_max_ff       <= max_ff;
         out_max_col_ff   <= max_col_ff;
         out_max_row_ff   <= max_row_ff;
         out_mean_ff      <= (count_ff == '0) ? 16'd0 : mean_ff;
         out_rms_ff       <= (count_ff == '0) ? 16'd0 : sq_res_ff[15:0];
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_count = out_count_ff;
   assign rsp_min_found   = out_min_found_ff;
   assign rsp_min_value   = out_min_ff;
   assign rsp_min_col     = out_min_col_ff;
   assign rsp_min_row     = out_min_row_ff;
   assign rsp_max_found   = out_max_found_ff;
   assign rsp_max_value   = out_max_ff;
   assign rsp_max_col     = out_max_col_ff;
   assign rsp_max_row     = out_max_row_ff;
   assign rsp_mean_q8     = out_mean_ff;
   assign rsp_rms_q8      = out_rms_ff;

endmodule

>>> sv/threshold_map_statistics.sv
// Top level of the threshold map statistics block.
// Pixels are taken one per cycle while the input is not stalled; each is folded into the accumulators.
// After the last pixel the input stalls while the products are formed and through a 16-step
// and a 30-step pass of one shared restoring divider and a 15-step square root.
// The result is registered once the output is free after the root; a stalled result holds it back.
// Synchronous active-high reset clears the control state and the accumulators.
module threshold_map_statistics import tms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_threshold,
   input  logic [5:0]  req_pixel_col,
   input  logic [6:0]  req_pixel_row,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_valid_count,
   output logic        rsp_min_found,
   output logic [7:0]  rsp_min_value,
   output logic [5:0]  rsp_min_col,
   output logic [6:0]  rsp_min_row,
   output logic        rsp_max_found,
   output logic [7:0]  rsp_max_value,
   output logic [5:0]  rsp_max_col,
   output logic [6:0]  rsp_max_row,
   output logic [15:0] rsp_mean_q8,
   output logic [15:0] rsp_rms_q8
);

   tms_cmd_type    cmd;
   tms_status_type status;

   tms_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_pixel (req_last_pixel),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   tms_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_threshold   (req_threshold),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_count (rsp_valid_count),
      .rsp_min_found   (rsp_min_found),
      .rsp_min_value   (rsp_min_value),
      .rsp_min_col     (rsp_min_col),
      .rsp_min_row     (rsp_min_row),
      .rsp_max_found   (rsp_max_found),
      .rsp_max_value   (rsp_max_value),
      .rsp_max_col     (rsp_max_col),
      .rsp_max_row     (rsp_max_row),
      .rsp_mean_q8     (rsp_mean_q8),
      .rsp_rms_q8      (rsp_rms_q8)
   );

endmodule

>>> sv/tms_checker.sv
// Port-level assertion checker of the threshold map statistics block and its bind.
`include "threshold_map_statistics_assert.svh"

module tms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_last_pixel,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_min_found,
   input logic [7:0] rsp_min_value,
   input logic       rsp_max_found
);

   `TMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `TMS_ASSERT_NEXT(a_last_stalls, clock, reset, req_valid && !req_stall && req_last_pixel, req_stall)
   `TMS_ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   `TMS_ASSERT_SAME(a_found_match, clock, reset, rsp_valid, rsp_min_found == rsp_max_found)
   `TMS_ASSERT_SAME(a_no_min_value, clock, reset, rsp_valid && !rsp_min_found, rsp_min_value == 8'd255)

endmodule

bind threshold_map_statistics tms_checker u_tms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last_pixel (req_last_pixel),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_min_found  (rsp_min_found),
   .rsp_min_value  (rsp_min_value),
   .rsp_max_found  (rsp_max_found)
);
